// ===== src/sar_pkg.sv =====
// Shared types, constants and the rotation routing table for the sensor axis rotation block.
// Used by sar_perm, sar_round and sensor_axis_rotation; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sar_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int MODE_W    = 5;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 15;
  localparam int SUM_W     = SAMPLE_W + 2;
  localparam int PROD_W    = SUM_W + COEF_W;
  localparam int ROUND_W   = PROD_W + 1;
  localparam int Q_W       = ROUND_W - FRAC_BITS;
  localparam int TDATA_W   = ((3 * SAMPLE_W + 7) / 8) * 8;

  localparam logic signed [COEF_W-1:0]  COEF_Q15 = COEF_W'(23167);
  localparam logic signed [ROUND_W-1:0] HALF_Q15 = ROUND_W'(16384);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } vec_t;

  typedef enum logic [MODE_W-1:0] {
    ROT_NONE                  = 5'd0,
    ROT_YAW90                 = 5'd1,
    ROT_YAW135                = 5'd2,
    ROT_YAW180                = 5'd3,
    ROT_YAW270                = 5'd4,
    ROT_ROLL180               = 5'd5,
    ROT_ROLL180_YAW90         = 5'd6,
    ROT_PITCH180              = 5'd7,
    ROT_ROLL180_YAW270        = 5'd8,
    ROT_ROLL90                = 5'd9,
    ROT_ROLL90_YAW90          = 5'd10,
    ROT_ROLL270               = 5'd11,
    ROT_ROLL270_YAW90         = 5'd12,
    ROT_PITCH90               = 5'd13,
    ROT_PITCH270              = 5'd14,
    ROT_PITCH180_YAW90        = 5'd15,
    ROT_PITCH180_YAW270       = 5'd16,
    ROT_ROLL90_PITCH90        = 5'd17,
    ROT_ROLL180_PITCH90       = 5'd18,
    ROT_ROLL270_PITCH90       = 5'd19,
    ROT_ROLL90_PITCH180       = 5'd20,
    ROT_ROLL270_PITCH180      = 5'd21,
    ROT_ROLL90_PITCH270       = 5'd22,
    ROT_ROLL180_PITCH270      = 5'd23,
    ROT_ROLL270_PITCH270      = 5'd24,
    ROT_ROLL90_PITCH180_YAW90 = 5'd25,
    ROT_ROLL90_YAW270         = 5'd26
  } rot_mode_t;

  typedef enum logic [1:0] {
    SRC_X,
    SRC_Y,
    SRC_Z
  } src_t;

  // Saturating negations applied to one axis: twice turns the minimum into minus the maximum.
  typedef enum logic [1:0] {
    NEG_NONE,
    NEG_ONCE,
    NEG_TWICE
  } negc_t;

  typedef struct packed {
    src_t  src_x;
    negc_t neg_x;
    src_t  src_y;
    negc_t neg_y;
    src_t  src_z;
    negc_t neg_z;
    logic  yaw135;
  } route_t;

  function automatic route_t mk_route(src_t sx, negc_t nx, src_t sy, negc_t ny,
                                      src_t sz, negc_t nz);
    route_t r;
    r.src_x  = sx;
    r.neg_x  = nx;
    r.src_y  = sy;
    r.neg_y  = ny;
    r.src_z  = sz;
    r.neg_z  = nz;
    r.yaw135 = 1'b0;
    return r;
  endfunction

  function automatic route_t decode_route(logic [MODE_W-1:0] mode);
    route_t r;
    r = mk_route(SRC_X, NEG_NONE, SRC_Y, NEG_NONE, SRC_Z, NEG_NONE);
    case (mode)
      ROT_YAW90:                 r = mk_route(SRC_Y, NEG_ONCE,  SRC_X, NEG_NONE,  SRC_Z, NEG_NONE);
      ROT_YAW135:                r.yaw135 = 1'b1;
      ROT_YAW180:                r = mk_route(SRC_X, NEG_ONCE,  SRC_Y, NEG_ONCE,  SRC_Z, NEG_NONE);
      ROT_YAW270:                r = mk_route(SRC_Y, NEG_NONE,  SRC_X, NEG_ONCE,  SRC_Z, NEG_NONE);
      ROT_ROLL180:               r = mk_route(SRC_X, NEG_NONE,  SRC_Y, NEG_ONCE,  SRC_Z, NEG_ONCE);
      ROT_ROLL180_YAW90:         r = mk_route(SRC_Y, NEG_NONE,  SRC_X, NEG_NONE,  SRC_Z, NEG_ONCE);
      ROT_PITCH180:              r = mk_route(SRC_X, NEG_ONCE,  SRC_Y, NEG_NONE,  SRC_Z, NEG_ONCE);
      ROT_ROLL180_YAW270:        r = mk_route(SRC_Y, NEG_ONCE,  SRC_X, NEG_ONCE,  SRC_Z, NEG_ONCE);
      ROT_ROLL90:                r = mk_route(SRC_X, NEG_NONE,  SRC_Z, NEG_ONCE,  SRC_Y, NEG_NONE);
      ROT_ROLL90_YAW90:          r = mk_route(SRC_Z, NEG_TWICE, SRC_X, NEG_NONE,  SRC_Y, NEG_NONE);
      ROT_ROLL270:               r = mk_route(SRC_X, NEG_NONE,  SRC_Z, NEG_NONE,  SRC_Y, NEG_ONCE);
      ROT_ROLL270_YAW90:         r = mk_route(SRC_Z, NEG_ONCE,  SRC_X, NEG_NONE,  SRC_Y, NEG_ONCE);
      ROT_PITCH90:               r = mk_route(SRC_Z, NEG_NONE,  SRC_Y, NEG_NONE,  SRC_X, NEG_ONCE);
      ROT_PITCH270:              r = mk_route(SRC_Z, NEG_ONCE,  SRC_Y, NEG_NONE,  SRC_X, NEG_NONE);
      ROT_PITCH180_YAW90:        r = mk_route(SRC_Y, NEG_ONCE,  SRC_X, NEG_ONCE,  SRC_Z, NEG_ONCE);
      ROT_PITCH180_YAW270:       r = mk_route(SRC_Y, NEG_NONE,  SRC_X, NEG_TWICE, SRC_Z, NEG_ONCE);
      ROT_ROLL90_PITCH90:        r = mk_route(SRC_Y, NEG_NONE,  SRC_Z, NEG_ONCE,  SRC_X, NEG_ONCE);
      ROT_ROLL180_PITCH90:       r = mk_route(SRC_Z, NEG_ONCE,  SRC_Y, NEG_ONCE,  SRC_X, NEG_ONCE);
      ROT_ROLL270_PITCH90:       r = mk_route(SRC_Y, NEG_ONCE,  SRC_Z, NEG_NONE,  SRC_X, NEG_ONCE);
      ROT_ROLL90_PITCH180:       r = mk_route(SRC_X, NEG_ONCE,  SRC_Z, NEG_ONCE,  SRC_Y, NEG_ONCE);
      ROT_ROLL270_PITCH180:      r = mk_route(SRC_X, NEG_ONCE,  SRC_Z, NEG_NONE,  SRC_Y, NEG_TWICE);
      ROT_ROLL90_PITCH270:       r = mk_route(SRC_Y, NEG_ONCE,  SRC_Z, NEG_ONCE,  SRC_X, NEG_NONE);
      ROT_ROLL180_PITCH270:      r = mk_route(SRC_Z, NEG_TWICE, SRC_Y, NEG_ONCE,  SRC_X, NEG_NONE);
      ROT_ROLL270_PITCH270:      r = mk_route(SRC_Y, NEG_TWICE, SRC_Z, NEG_NONE,  SRC_X, NEG_NONE);
      ROT_ROLL90_PITCH180_YAW90: r = mk_route(SRC_Z, NEG_TWICE, SRC_X, NEG_ONCE,  SRC_Y, NEG_ONCE);
      ROT_ROLL90_YAW270:         r = mk_route(SRC_Z, NEG_ONCE,  SRC_X, NEG_ONCE,  SRC_Y, NEG_NONE);
      default:                   r.yaw135 = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/sar_perm.sv =====
// Axis swap and saturating negation of one vector along a decoded route.
// Depends on sar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sar_perm (
  input  sar_pkg::vec_t   vec_in,
  input  sar_pkg::route_t route,
  output sar_pkg::vec_t   vec_out
);

  function automatic sar_pkg::sample_t pick(sar_pkg::vec_t v, sar_pkg::src_t s);
    sar_pkg::sample_t r;
    case (s)
      sar_pkg::SRC_X: r = v.x;
      sar_pkg::SRC_Y: r = v.y;
      sar_pkg::SRC_Z: r = v.z;
      default:        r = v.x;
    endcase
    return r;
  endfunction

  function automatic sar_pkg::sample_t apply_neg(sar_pkg::sample_t v, sar_pkg::negc_t n);
    sar_pkg::sample_t r;
    logic             is_min;
    is_min = (v == sar_pkg::SAMPLE_MIN);
    case (n)
      sar_pkg::NEG_ONCE:  r = is_min ? sar_pkg::SAMPLE_MAX : -v;
      sar_pkg::NEG_TWICE: r = is_min ? -sar_pkg::SAMPLE_MAX : v;
      default:            r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    vec_out.x = apply_neg(pick(vec_in, route.src_x), route.neg_x);
    vec_out.y = apply_neg(pick(vec_in, route.src_y), route.neg_y);
    vec_out.z = apply_neg(pick(vec_in, route.src_z), route.neg_z);
  end

endmodule

`default_nettype wire

// ===== src/sar_round.sv =====
// Round-to-nearest and saturation of one Q15-scaled product back to sample range.
// Depends on sar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sar_round (
  input  sar_pkg::prod_t   prod,
  output sar_pkg::sample_t result
);

  logic signed [sar_pkg::ROUND_W-1:0] biased;
  logic signed [sar_pkg::Q_W-1:0]     quot;
  logic                               fits;

  always_comb begin
    biased = {prod[sar_pkg::PROD_W-1], prod} + sar_pkg::HALF_Q15;
    quot   = biased[sar_pkg::ROUND_W-1:sar_pkg::FRAC_BITS];
    fits   = (&quot[sar_pkg::Q_W-1:sar_pkg::SAMPLE_W-1]) |
             ~(|quot[sar_pkg::Q_W-1:sar_pkg::SAMPLE_W-1]);
    if (fits) begin
      result = quot[sar_pkg::SAMPLE_W-1:0];
    end else if (quot[sar_pkg::Q_W-1]) begin
      result = sar_pkg::SAMPLE_MIN;
    end else begin
      result = sar_pkg::SAMPLE_MAX;
    end
  end

endmodule

`default_nettype wire

// ===== src/sensor_axis_rotation.sv =====
// Top level: three-stage stream pipeline rotating sensor vectors into board orientation.
// Depends on sar_pkg, sar_perm and sar_round.
//
//   channel  | direction | handshake             | payload
//   in_      | slave     | in_tvalid/in_tready   | in_tdata: x, y, z (24 bits each)
//   out_     | master    | out_tvalid/out_tready | out_tdata: x, y, z (24 bits each)
//   cfg_     | write     | cfg_wr_en             | cfg_wr_data: rotation_mode
//
// Three register stages: an accepted input passes through stages 1, 2 and 3 before out_tvalid
// rises; one item per cycle sustained while out_tready stays high.
// Stage 1 registers the sample, the decoded route and the yaw-135 sums; stage 2 holds the
// permuted vector and the two 26x16 products; stage 3 rounds, saturates and drives out_.
// Each stage loads when it is empty or the next stage moves, so bubbles close up under stall.
// Reset clears the stage valid bits and sets rotation_mode to none.
`timescale 1ns / 1ps
`default_nettype none

module sensor_axis_rotation (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [sar_pkg::TDATA_W-1:0]  in_tdata,   // in_x, in_y, in_z
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [sar_pkg::TDATA_W-1:0]  out_tdata,  // out_x, out_y, out_z
  input  wire logic                         cfg_wr_en,
  input  wire logic [sar_pkg::MODE_W-1:0]   cfg_wr_data
);

  logic [sar_pkg::MODE_W-1:0] mode_r, mode_nxt;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic en1, en2, en3;

  sar_pkg::vec_t   in_vec;
  sar_pkg::sum_t   sum_a, sum_b;

  sar_pkg::vec_t   vec1_r;
  sar_pkg::route_t route1_r;
  sar_pkg::sum_t   sa1_r, sb1_r;

  sar_pkg::vec_t   perm_vec;
  sar_pkg::vec_t   vec2_r;
  sar_pkg::prod_t  pa2_r, pb2_r;
  logic            yaw2_r;

  sar_pkg::sample_t rx, ry;
  sar_pkg::vec_t    vec3_r, vec3_nxt;

  assign in_vec.x = in_tdata[sar_pkg::SAMPLE_W-1:0];
  assign in_vec.y = in_tdata[2*sar_pkg::SAMPLE_W-1:sar_pkg::SAMPLE_W];
  assign in_vec.z = in_tdata[3*sar_pkg::SAMPLE_W-1:2*sar_pkg::SAMPLE_W];

  always_comb begin
    sum_a = -sar_pkg::sum_t'(in_vec.x) - sar_pkg::sum_t'(in_vec.y);
    sum_b =  sar_pkg::sum_t'(in_vec.x) - sar_pkg::sum_t'(in_vec.y);
  end

  always_comb begin
    mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;
    en3      = !v3_r || out_tready;
    en2      = !v2_r || en3;
    en1      = !v1_r || en2;
    v1_nxt   = en1 ? in_tvalid : v1_r;
    v2_nxt   = en2 ? v1_r : v2_r;
    v3_nxt   = en3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sar_pkg::ROT_NONE;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
      v3_r   <= v3_nxt;
    end
  end

  // Stage 1: capture sample, route and yaw-135 sums.
  always_ff @(posedge clk) begin
    if (en1) begin
      vec1_r   <= in_vec;
      route1_r <= sar_pkg::decode_route(mode_r);
      sa1_r    <= sum_a;
      sb1_r    <= sum_b;
    end
  end

  sar_perm u_perm (
    .vec_in  (vec1_r),
    .route   (route1_r),
    .vec_out (perm_vec)
  );

  // Stage 2: permuted vector and coefficient products.
  always_ff @(posedge clk) begin
    if (en2) begin
      vec2_r <= perm_vec;
      pa2_r  <= sa1_r * sar_pkg::COEF_Q15;
      pb2_r  <= sb1_r * sar_pkg::COEF_Q15;
      yaw2_r <= route1_r.yaw135;
    end
  end

  sar_round u_round_x (
    .prod   (pa2_r),
    .result (rx)
  );

  sar_round u_round_y (
    .prod   (pb2_r),
    .result (ry)
  );

  always_comb begin
    vec3_nxt = vec2_r;
    if (yaw2_r) begin
      vec3_nxt.x = rx;
      vec3_nxt.y = ry;
    end
  end

  // Stage 3: output register.
  always_ff @(posedge clk) begin
    if (en3) begin
      vec3_r <= vec3_nxt;
    end
  end

  assign in_tready  = en1;
  assign out_tvalid = v3_r;
  assign out_tdata  = {{(sar_pkg::TDATA_W - 3*sar_pkg::SAMPLE_W){1'b0}},
                       vec3_r.z, vec3_r.y, vec3_r.x};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for sensor_axis_rotation: drives sensor vectors through every mounting rotation code
// and checks each rotated item against an in-bench predictor. Depends on sar_pkg and the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int     HALF_PERIOD = 4;
  localparam int     HOLD_CYCLES = 64;
  localparam longint AXIS_MAX    = (longint'(1) <<< (sar_pkg::SAMPLE_W - 1)) - 1;
  localparam longint AXIS_MIN    = -AXIS_MAX - 1;
  localparam longint YAW135_COEF = 23167;
  localparam longint ROUND_HALF  = 16384;
  localparam logic [sar_pkg::MODE_W-1:0] MODE_LAST = '1;
  localparam logic [sar_pkg::MODE_W-1:0] MODE_FIRST_UNUSED =
    sar_pkg::MODE_W'(int'(sar_pkg::ROT_ROLL90_YAW270) + 1);

  typedef struct {
    sar_pkg::sample_t x;
    sar_pkg::sample_t y;
    sar_pkg::sample_t z;
  } vec3_t;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_tvalid   = 1'b0;
  logic                         in_tready;
  logic [sar_pkg::TDATA_W-1:0]  in_tdata    = '0;  // in_x, in_y, in_z
  logic                         out_tvalid;
  logic                         out_tready  = 1'b0;
  logic [sar_pkg::TDATA_W-1:0]  out_tdata;         // out_x, out_y, out_z
  logic                         cfg_wr_en   = 1'b0;
  logic [sar_pkg::MODE_W-1:0]   cfg_wr_data = '0;

  logic [sar_pkg::MODE_W-1:0]   board_mode = sar_pkg::ROT_NONE;
  vec3_t                        rotated_q[$];
  bit                           idle_on = 1'b1;
  bit                           hold_req = 1'b0;
  int                           err_cnt = 0;
  int                           mismatch_cnt = 0;

  sensor_axis_rotation dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic longint clamp_axis(longint v);
    if (v > AXIS_MAX) return AXIS_MAX;
    if (v < AXIS_MIN) return AXIS_MIN;
    return v;
  endfunction

  function automatic longint flip(longint v);
    return clamp_axis(-v);
  endfunction

  // Round to nearest with ties upward: the arithmetic shift floors.
  function automatic longint scale_yaw135(longint s);
    longint p;
    p = s * YAW135_COEF + ROUND_HALF;
    return clamp_axis(p >>> 15);
  endfunction

  function automatic vec3_t rotate_vec(logic [sar_pkg::MODE_W-1:0] mode, vec3_t v);
    longint x, y, z, t;
    vec3_t  r;
    x = v.x;
    y = v.y;
    z = v.z;
    case (mode)
      sar_pkg::ROT_YAW90: begin
        t = x; x = flip(y); y = t;
      end
      sar_pkg::ROT_YAW135: begin
        t = x; x = scale_yaw135(-x - y); y = scale_yaw135(t - y);
      end
      sar_pkg::ROT_YAW180: begin
        x = flip(x); y = flip(y);
      end
      sar_pkg::ROT_YAW270: begin
        t = x; x = y; y = flip(t);
      end
      sar_pkg::ROT_ROLL180: begin
        y = flip(y); z = flip(z);
      end
      sar_pkg::ROT_ROLL180_YAW90: begin
        t = x; x = y; y = t; z = flip(z);
      end
      sar_pkg::ROT_PITCH180: begin
        x = flip(x); z = flip(z);
      end
      sar_pkg::ROT_ROLL180_YAW270: begin
        t = x; x = flip(y); y = flip(t); z = flip(z);
      end
      sar_pkg::ROT_ROLL90: begin
        t = z; z = y; y = flip(t);
      end
      sar_pkg::ROT_ROLL90_YAW90: begin
        t = z; z = y; y = flip(t);
        t = x; x = flip(y); y = t;
      end
      sar_pkg::ROT_ROLL270: begin
        t = z; z = flip(y); y = t;
      end
      sar_pkg::ROT_ROLL270_YAW90: begin
        t = z; z = flip(y); y = t;
        t = x; x = flip(y); y = t;
      end
      sar_pkg::ROT_PITCH90: begin
        t = z; z = flip(x); x = t;
      end
      sar_pkg::ROT_PITCH270: begin
        t = z; z = x; x = flip(t);
      end
      sar_pkg::ROT_PITCH180_YAW90: begin
        z = flip(z);
        t = flip(x); x = flip(y); y = t;
      end
      sar_pkg::ROT_PITCH180_YAW270: begin
        x = flip(x); z = flip(z);
        t = x; x = y; y = flip(t);
      end
      sar_pkg::ROT_ROLL90_PITCH90: begin
        t = z; z = y; y = flip(t);
        t = z; z = flip(x); x = t;
      end
      sar_pkg::ROT_ROLL180_PITCH90: begin
        y = flip(y); z = flip(z);
        t = z; z = flip(x); x = t;
      end
      sar_pkg::ROT_ROLL270_PITCH90: begin
        t = z; z = flip(y); y = t;
        t = z; z = flip(x); x = t;
      end
      sar_pkg::ROT_ROLL90_PITCH180: begin
        t = z; z = y; y = flip(t);
        x = flip(x); z = flip(z);
      end
      sar_pkg::ROT_ROLL270_PITCH180: begin
        t = z; z = flip(y); y = t;
        x = flip(x); z = flip(z);
      end
      sar_pkg::ROT_ROLL90_PITCH270: begin
        t = z; z = y; y = flip(t);
        t = z; z = x; x = flip(t);
      end
      sar_pkg::ROT_ROLL180_PITCH270: begin
        y = flip(y); z = flip(z);
        t = z; z = x; x = flip(t);
      end
      sar_pkg::ROT_ROLL270_PITCH270: begin
        t = z; z = flip(y); y = t;
        t = z; z = x; x = flip(t);
      end
      sar_pkg::ROT_ROLL90_PITCH180_YAW90: begin
        t = z; z = y; y = flip(t);
        x = flip(x); z = flip(z);
        t = x; x = flip(y); y = t;
      end
      sar_pkg::ROT_ROLL90_YAW270: begin
        t = z; z = y; y = flip(t);
        t = x; x = y; y = flip(t);
      end
      default: ;
    endcase
    r.x = sar_pkg::sample_t'(x);
    r.y = sar_pkg::sample_t'(y);
    r.z = sar_pkg::sample_t'(z);
    return r;
  endfunction

  function automatic sar_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return sar_pkg::SAMPLE_MIN;
      1:       return sar_pkg::SAMPLE_MAX;
      2:       return sar_pkg::sample_t'(int'($urandom_range(0, 40000)) - 20000);
      3:       return sar_pkg::SAMPLE_MIN + sar_pkg::sample_t'($urandom_range(0, 3));
      default: return sar_pkg::sample_t'($urandom());
    endcase
  endfunction

  task automatic send_vec(input sar_pkg::sample_t x, input sar_pkg::sample_t y,
                          input sar_pkg::sample_t z);
    vec3_t v;
    int    gap;
    v.x = x;
    v.y = y;
    v.z = z;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tdata  <= sar_pkg::TDATA_W'({$urandom(), $urandom(), $urandom()});
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    rotated_q.push_back(rotate_vec(board_mode, v));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_vec(pick_sample(), pick_sample(), pick_sample());
  endtask

  // Drop valid and wait until every rotated item has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic [sar_pkg::MODE_W-1:0] mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board_mode = mode;
  endtask

  task automatic test_reset_mode();
    send_vec(sar_pkg::SAMPLE_MIN, sar_pkg::SAMPLE_MAX, -24'sd1);
    send_vec(sar_pkg::SAMPLE_MAX, sar_pkg::SAMPLE_MIN, 24'sd1);
    send_vec('0, '0, '0);
    drain();
  endtask

  task automatic test_yaw135_rounding();
    write_mode(sar_pkg::ROT_YAW135);
    send_vec(-24'sd16384, '0, '0);
    send_vec(24'sd16384, '0, 24'sd5);
    send_vec(sar_pkg::SAMPLE_MIN, sar_pkg::SAMPLE_MIN, sar_pkg::SAMPLE_MAX);
    send_vec(sar_pkg::SAMPLE_MIN, sar_pkg::SAMPLE_MAX, sar_pkg::SAMPLE_MIN);
    send_vec(sar_pkg::SAMPLE_MAX, sar_pkg::SAMPLE_MAX, '0);
    send_vec(24'sd1, '0, '0);
    send_vec(-24'sd1, '0, '0);
    send_vec('0, 24'sd1, -24'sd1);
    drain();
  endtask

  task automatic test_min_negation();
    logic [sar_pkg::MODE_W-1:0] modes[7];
    modes = '{sar_pkg::ROT_YAW180, sar_pkg::ROT_ROLL90_YAW90, sar_pkg::ROT_PITCH180_YAW270,
              sar_pkg::ROT_ROLL270_PITCH180, sar_pkg::ROT_ROLL180_PITCH270,
              sar_pkg::ROT_ROLL270_PITCH270, sar_pkg::ROT_ROLL90_PITCH180_YAW90};
    foreach (modes[i]) begin
      write_mode(modes[i]);
      send_vec(sar_pkg::SAMPLE_MIN, sar_pkg::SAMPLE_MIN, sar_pkg::SAMPLE_MIN);
      drain();
    end
  endtask

  task automatic test_unused_codes();
    write_mode(MODE_FIRST_UNUSED);
    send_vec(sar_pkg::SAMPLE_MIN, sar_pkg::SAMPLE_MAX, 24'sd12345);
    drain();
    write_mode(MODE_LAST);
    send_vec(sar_pkg::SAMPLE_MAX, sar_pkg::SAMPLE_MIN, -24'sd12345);
    drain();
  endtask

  task automatic test_mode_sweep();
    for (int m = 0; m <= int'(MODE_LAST); m++) begin
      write_mode(m[sar_pkg::MODE_W-1:0]);
      send_random(28);
      drain();
    end
    repeat (12) begin
      write_mode(sar_pkg::MODE_W'($urandom_range(0, int'(MODE_LAST))));
      send_random(28);
      drain();
    end
  endtask

  // Hold the receiver off while items keep coming, so the pipeline fills and stalls.
  task automatic test_backpressure();
    write_mode(sar_pkg::MODE_W'($urandom_range(int'(sar_pkg::ROT_YAW90),
                                                int'(sar_pkg::ROT_ROLL90_YAW270))));
    hold_req = 1'b1;
    send_random(40);
    drain();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    write_mode(sar_pkg::ROT_YAW135);
    send_random(60);
    drain();
    write_mode(sar_pkg::ROT_ROLL90_PITCH180_YAW90);
    send_random(60);
    drain();
  endtask

  initial begin
    int hold_cnt;
    int burst;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_tready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    vec3_t want;
    vec3_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[sar_pkg::SAMPLE_W-1:0];
      got.y = out_tdata[2*sar_pkg::SAMPLE_W-1:sar_pkg::SAMPLE_W];
      got.z = out_tdata[3*sar_pkg::SAMPLE_W-1:2*sar_pkg::SAMPLE_W];
      if (rotated_q.size() == 0) begin
        err_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected item x=%0d y=%0d z=%0d", got.x, got.y, got.z);
      end else begin
        want = rotated_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          err_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch mode %0d: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
                     board_mode, want.x, want.y, want.z, got.x, got.y, got.z);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_mode();
    test_yaw135_rounding();
    test_min_negation();
    test_unused_codes();
    test_mode_sweep();
    test_backpressure();
    test_full_rate();
    repeat (8) @(posedge clk);
    err_cnt += rotated_q.size();
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sensor_axis_rotation.f =====
src/sar_pkg.sv
src/sar_perm.sv
src/sar_round.sv
src/sensor_axis_rotation.sv
bench/tb_top.sv
